### hw/rtl/ptec_pkg.sv
// Package for the partition table entry checker: widths, magic codes,
// alignment and flag constants, status codes and the shared struct types.
// No dependencies.
`default_nettype none

package ptec_pkg;

   localparam int unsigned MaxEntriesDefault = 95;
   localparam int unsigned CountWidth        = 7;
   localparam int unsigned OffsetWidth       = 32;
   localparam int unsigned EndWidth          = 33;

   localparam logic [15:0] MagicEntry = 16'h50aa;
   localparam logic [15:0] MagicMd5   = 16'hebeb;
   localparam logic [15:0] MagicEnd   = 16'hffff;

   localparam logic [31:0] AlignApp      = 32'h0001_0000;
   localparam logic [31:0] AlignOther    = 32'h0000_1000;
   localparam logic [31:0] FlagEncrypted = 32'h0000_0001;
   localparam logic [31:0] FlagReadOnly  = 32'h0000_0002;

   localparam logic [7:0] TypeApp = 8'h00;

   typedef logic [CountWidth-1:0] count_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_END       = 3'd1,
      ST_MD5       = 3'd2,
      ST_BAD_MAGIC = 3'd3,
      ST_FULL      = 3'd4,
      ST_IGNORED   = 3'd5
   } status_type;

   typedef struct packed {
      logic        first_entry;
      logic [15:0] entry_magic;
      logic [7:0]  entry_type;
      logic [7:0]  entry_subtype;
      logic [31:0] flash_offset;
      logic [31:0] flash_length;
      logic [31:0] part_flags;
   } req_payload_type;

   typedef struct packed {
      status_type status;
      count_type  entry_index;
      logic       is_empty;
      logic       is_misaligned;
      logic       does_overlap;
      logic       is_encrypted;
      logic       is_read_only;
      count_type  stored_total;
   } rsp_payload_type;

   typedef struct packed {
      logic                   start;
      count_type              limit;
      logic [OffsetWidth-1:0] item_start;
      logic [EndWidth-1:0]    item_end;
   } scan_ctrl_type;

   typedef struct packed {
      logic done;
      logic hit;
   } scan_stat_type;

endpackage

`default_nettype wire

### hw/rtl/ptec_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Source drives valid and payload, sink drives ready.
`default_nettype none

interface ptec_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/ptec_range_mem.sv
// Stored partition ranges: start offsets and 33-bit ends.
// One write port, one registered read port. Uses ptec_pkg.
`default_nettype none

module ptec_range_mem
   import ptec_pkg::*;
#(
   parameter int unsigned Depth     = MaxEntriesDefault,
   parameter int unsigned AddrWidth = 7
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AddrWidth-1:0]   wr_addr,
   input  logic [OffsetWidth-1:0] wr_start,
   input  logic [EndWidth-1:0]    wr_end,
   input  logic [AddrWidth-1:0]   rd_addr,
   output logic [OffsetWidth-1:0] rd_start,
   output logic [EndWidth-1:0]    rd_end
);

   logic [OffsetWidth-1:0] start_mem [Depth];
   logic [EndWidth-1:0]    end_mem   [Depth];
   logic [OffsetWidth-1:0] rd_start_ff;
   logic [EndWidth-1:0]    rd_end_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr] <= wr_start;
         end_mem[wr_addr]   <= wr_end;
      end
   end

   always_ff @(posedge clock) begin
      rd_start_ff <= start_mem[rd_addr];
      rd_end_ff   <= end_mem[rd_addr];
   end

   assign rd_start = rd_start_ff;
   assign rd_end   = rd_end_ff;

endmodule

`default_nettype wire

### hw/rtl/ptec_scan_seq.sv
// Overlap scan sequencer: walks stored ranges one per cycle through the
// range memory read port and runs one shared range compare. Uses ptec_pkg.
`default_nettype none

module ptec_scan_seq
   import ptec_pkg::*;
#(
   parameter int unsigned MaxEntries = MaxEntriesDefault,
   parameter int unsigned AddrWidth  = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scan_ctrl_type          ctrl,
   output scan_stat_type          stat,
   output logic [AddrWidth-1:0]   rd_addr,
   input  logic [OffsetWidth-1:0] rd_start,
   input  logic [EndWidth-1:0]    rd_end
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_DONE = 3'b100
   } seq_state_type;

   seq_state_type          state_ff, state_in;
   count_type              issue_ff, issue_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   hit_ff, hit_in;
   count_type              limit_ff, limit_in;
   logic [OffsetWidth-1:0] start_ff, start_in;
   logic [EndWidth-1:0]    end_ff, end_in;
   logic                   issuing;
   logic                   range_hit;

   assign issuing   = (issue_ff != limit_ff);
   assign range_hit = ({1'b0, start_ff} < rd_end) && ({1'b0, rd_start} < end_ff);

   always_comb begin
      state_in  = state_ff;
      issue_in  = issue_ff;
      rd_vld_in = 1'b0;
      hit_in    = hit_ff;
      limit_in  = limit_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      case (state_ff)
         S_IDLE, S_DONE: begin
            if (ctrl.start) begin
               state_in = S_RUN;
               issue_in = '0;
               hit_in   = 1'b0;
               limit_in = ctrl.limit;
               start_in = ctrl.item_start;
               end_in   = ctrl.item_end;
            end
         end
         S_RUN: begin
            rd_vld_in = issuing;
            if (issuing) begin
               issue_in = issue_ff + count_type'(1);
            end
            if (rd_vld_ff && range_hit) begin
               hit_in = 1'b1;
            end
            if (!issuing && !rd_vld_ff) begin
               state_in = S_DONE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issue_ff  <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         limit_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= rd_vld_in;
         hit_ff    <= hit_in;
         limit_ff  <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign rd_addr   = issue_ff[AddrWidth-1:0];
   assign stat.done = (state_ff == S_DONE);
   assign stat.hit  = hit_ff;

`ifndef SYNTH
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_ff <= limit_ff)
      else $error("scan issued past stored count");

   a_limit_bound: assert property (@(posedge clock) disable iff (reset)
      limit_ff <= count_type'(MaxEntries))
      else $error("scan limit beyond table depth");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && !issuing && !rd_vld_ff) |=> (state_ff == S_DONE))
      else $error("scan did not finish after last compare");
`endif

endmodule

`default_nettype wire

### hw/rtl/partition_table_entry_checker.sv
// Partition table entry checker top level: entry classification, table
// state, result register. Uses ptec_pkg, ptec_chan_if, ptec_range_mem,
// ptec_scan_seq.
//
//   channel  | dir | item
//   ---------+-----+-------------------------------------------
//   req_ch   | in  | decoded partition table entry (129 bits)
//   rsp_ch   | out | check status, index, flags, stored total
//
// An accepted entry with ranges already stored waits for an overlap scan over them,
// one compare per cycle from the single range memory read port; every other item,
// an entry into an empty table included, gets its result without a scan.
// Reset clears entry count, stop flag and handshake state; ranges are not
// cleared, only entries below the count are read.
// A stalled result holds in the output register; a new item is taken on the
// edge at which the pending result leaves.
`default_nettype none

module partition_table_entry_checker
   import ptec_pkg::*;
#(
   parameter int unsigned MaxEntries = MaxEntriesDefault
) (
   input  logic         clock,
   input  logic         reset,
   ptec_chan_if.sink    req_ch,
   ptec_chan_if.source  rsp_ch
);

   localparam int unsigned AddrWidth = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } top_state_type;

   top_state_type          state_ff, state_in;
   count_type              count_ff, count_in;
   logic                   stop_ff, stop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;
   rsp_payload_type        pend_ff, pend_in;

   req_payload_type        req_item;
   count_type              eff_count;
   logic                   eff_stop;
   logic                   is_full;
   logic                   accepted;
   logic                   stops_scan;
   logic                   need_scan;
   logic                   out_free;
   logic                   req_fire;
   logic                   scan_finish;
   logic [EndWidth-1:0]    item_end;
   logic [31:0]            align_mask;
   rsp_payload_type        cls_rsp;

   scan_ctrl_type          scan_ctrl;
   scan_stat_type          scan_stat;
   logic [AddrWidth-1:0]   rd_addr;
   logic [OffsetWidth-1:0] rd_start;
   logic [EndWidth-1:0]    rd_end;

   assign req_item    = req_ch.payload;
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire    = req_ch.valid && req_ch.ready;
   assign scan_finish = (state_ff == S_SCAN) && scan_stat.done && out_free;

   assign eff_count = req_item.first_entry ? '0 : count_ff;
   assign eff_stop  = req_item.first_entry ? 1'b0 : stop_ff;
   assign is_full   = (eff_count >= count_type'(MaxEntries));
   assign item_end  = {1'b0, req_item.flash_offset} + {1'b0, req_item.flash_length};
   assign align_mask = (req_item.entry_type == TypeApp) ? (AlignApp - 32'd1)
                                                        : (AlignOther - 32'd1);

   always_comb begin
      cls_rsp    = '0;
      accepted   = 1'b0;
      stops_scan = 1'b0;
      if (eff_stop) begin
         cls_rsp.status = ST_IGNORED;
      end else if (is_full) begin
         cls_rsp.status = ST_FULL;
      end else if (req_item.entry_magic == MagicEnd) begin
         cls_rsp.status = ST_END;
         stops_scan     = 1'b1;
      end else if (req_item.entry_magic == MagicMd5) begin
         cls_rsp.status = ST_MD5;
         stops_scan     = 1'b1;
      end else if (req_item.entry_magic != MagicEntry) begin
         cls_rsp.status = ST_BAD_MAGIC;
         stops_scan     = 1'b1;
      end else begin
         cls_rsp.status        = ST_ACCEPTED;
         accepted              = 1'b1;
         cls_rsp.is_empty      = (req_item.flash_length == 32'd0);
         cls_rsp.is_misaligned = ((req_item.flash_offset & align_mask) != 32'd0);
         cls_rsp.is_encrypted  = ((req_item.part_flags & FlagEncrypted) != 32'd0);
         cls_rsp.is_read_only  = ((req_item.part_flags & FlagReadOnly) != 32'd0);
      end
      cls_rsp.entry_index  = eff_count;
      cls_rsp.stored_total = accepted ? (eff_count + count_type'(1)) : eff_count;
   end

   assign need_scan = accepted && (eff_count != '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      stop_in      = stop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               count_in = cls_rsp.stored_total;
               stop_in  = eff_stop || stops_scan;
               if (need_scan) begin
                  pend_in  = cls_rsp;
                  state_in = S_SCAN;
               end else begin
                  rsp_data_in  = cls_rsp;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (scan_finish) begin
               rsp_data_in              = pend_ff;
               rsp_data_in.does_overlap = scan_stat.hit;
               rsp_valid_in             = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   assign scan_ctrl.start      = req_fire && need_scan;
   assign scan_ctrl.limit      = eff_count;
   assign scan_ctrl.item_start = req_item.flash_offset;
   assign scan_ctrl.item_end   = item_end;

   ptec_range_mem #(
      .Depth     (MaxEntries),
      .AddrWidth (AddrWidth)
   ) u_range_mem (
      .clock    (clock),
      .wr_en    (req_fire && accepted),
      .wr_addr  (eff_count[AddrWidth-1:0]),
      .wr_start (req_item.flash_offset),
      .wr_end   (item_end),
      .rd_addr  (rd_addr),
      .rd_start (rd_start),
      .rd_end   (rd_end)
   );

   ptec_scan_seq #(
      .MaxEntries (MaxEntries),
      .AddrWidth  (AddrWidth)
   ) u_scan_seq (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_ctrl),
      .stat     (scan_stat),
      .rd_addr  (rd_addr),
      .rd_start (rd_start),
      .rd_end   (rd_end)
   );

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MaxEntries))
      else $error("entry count beyond table depth");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_item.first_entry && !accepted) |=> (count_ff == $past(count_ff)))
      else $error("entry count changed on a non-entry item");

   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      scan_finish |=> (rsp_valid_ff && rsp_data_ff.status == ST_ACCEPTED))
      else $error("finished scan did not load a result");

   a_flags_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_ACCEPTED) |->
         !(rsp_data_ff.is_empty || rsp_data_ff.is_misaligned || rsp_data_ff.does_overlap ||
           rsp_data_ff.is_encrypted || rsp_data_ff.is_read_only))
      else $error("check flags set on a non-entry result");
`endif

endmodule

`default_nettype wire

### tb/tb_partition_table_entry_checker.sv
// Self-checking testbench for partition_table_entry_checker: directed vectors, then random
// partition tables, each result held to a behavioral model of the table checks or to a
// hand-written result. Depends on ptec_pkg, ptec_chan_if and the checker RTL.
module tb_partition_table_entry_checker;
   import ptec_pkg::*;

   localparam int unsigned TableDepth  = MaxEntriesDefault;
   localparam int unsigned RandomItems = 500;
   localparam int unsigned StallLimit  = 3000;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } vector_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   ptec_chan_if #(.payload_type(req_payload_type)) req_ch ();
   ptec_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   partition_table_entry_checker #(.MaxEntries(TableDepth)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [31:0]     known_start [TableDepth];
   logic [32:0]     known_end [TableDepth];
   count_type       known_count = '0;
   logic            known_stopped = 1'b0;

   rsp_payload_type expected_verdicts [$];
   vector_row_type  directed_rows [$];
   int unsigned     items_sent = 0;
   int unsigned     useful_items = 0;
   int unsigned     tables_run = 0;
   int unsigned     results_seen = 0;
   int unsigned     error_count = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     status_tally [8];
   int unsigned     send_idle_pct = 6;
   int unsigned     recv_idle_pct = 88;

   function automatic rsp_payload_type predict_entry_check(req_payload_type e);
      rsp_payload_type r;
      logic [32:0]     span_end;
      logic [31:0]     align_mask;
      r = '0;
      if (e.first_entry) begin
         known_count   = '0;
         known_stopped = 1'b0;
      end
      r.entry_index = known_count;
      if (known_stopped) begin
         r.status = ST_IGNORED;
      end else if (known_count >= TableDepth) begin
         r.status = ST_FULL;
      end else if (e.entry_magic == MagicEnd) begin
         r.status      = ST_END;
         known_stopped = 1'b1;
      end else if (e.entry_magic == MagicMd5) begin
         r.status      = ST_MD5;
         known_stopped = 1'b1;
      end else if (e.entry_magic != MagicEntry) begin
         r.status      = ST_BAD_MAGIC;
         known_stopped = 1'b1;
      end else begin
         r.status      = ST_ACCEPTED;
         span_end      = {1'b0, e.flash_offset} + {1'b0, e.flash_length};
         align_mask    = (e.entry_type == TypeApp) ? AlignApp - 1 : AlignOther - 1;
         r.is_empty      = (e.flash_length == 0);
         r.is_misaligned = |(e.flash_offset & align_mask);
         r.is_encrypted  = |(e.part_flags & FlagEncrypted);
         r.is_read_only  = |(e.part_flags & FlagReadOnly);
         for (int k = 0; k < int'(known_count); k++) begin
            if ({1'b0, e.flash_offset} < known_end[k] && {1'b0, known_start[k]} < span_end)
               r.does_overlap = 1'b1;
         end
         known_start[known_count] = e.flash_offset;
         known_end[known_count]   = span_end;
         known_count              = known_count + 1'b1;
      end
      r.stored_total = known_count;
      return r;
   endfunction

   function automatic req_payload_type make_item(logic first, logic [15:0] magic,
                                                 logic [7:0] etype, logic [7:0] subtype,
                                                 logic [31:0] offset, logic [31:0] size,
                                                 logic [31:0] flags);
      req_payload_type e;
      e.first_entry   = first;
      e.entry_magic   = magic;
      e.entry_type    = etype;
      e.entry_subtype = subtype;
      e.flash_offset  = offset;
      e.flash_length  = size;
      e.part_flags    = flags;
      return e;
   endfunction

   function automatic req_payload_type random_item();
      return make_item(1'($urandom_range(1)), 16'($urandom), 8'($urandom), 8'($urandom),
                       $urandom, $urandom, $urandom);
   endfunction

   // marks: {empty, misaligned, overlap, encrypted, read-only}
   function automatic rsp_payload_type make_want(status_type st, count_type idx,
                                                 logic [4:0] marks, count_type total);
      rsp_payload_type r;
      r.status        = st;
      r.entry_index   = idx;
      {r.is_empty, r.is_misaligned, r.does_overlap, r.is_encrypted, r.is_read_only} = marks;
      r.stored_total  = total;
      return r;
   endfunction

   task automatic add_row(req_payload_type item, bit typed, rsp_payload_type want);
      vector_row_type row;
      row.item  = item;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic push_item(req_payload_type item, bit typed, rsp_payload_type want);
      rsp_payload_type verdict;
      if (useful_items < (RandomItems + 20) / 3) begin
         send_idle_pct = 6;
         recv_idle_pct = 88;
      end else if (useful_items < 2 * (RandomItems + 20) / 3) begin
         send_idle_pct = 88;
         recv_idle_pct = 6;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      verdict = predict_entry_check(item);
      expected_verdicts.push_back(typed ? want : verdict);
      items_sent++;
      if (verdict.status != ST_IGNORED)
         useful_items++;
   endtask

   // One table: entries mostly in order, some overlapping or random, then usually a
   // terminator and a few trailing items. Now and then a burst of pure noise instead.
   task automatic run_random_table();
      req_payload_type item;
      int unsigned     n;
      logic [31:0]     cursor;
      logic [31:0]     align;
      bit              long_table;
      if (tables_run > 0 && $urandom_range(9) == 0) begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < int'(n); k++)
            push_item(random_item(), 1'b0, '0);
      end else begin
         long_table = (tables_run == 0) || ($urandom_range(9) == 0);
         n = long_table ? $urandom_range(TableDepth - 4, TableDepth + 4) : $urandom_range(1, 16);
         cursor = $urandom_range(255) << 12;
         for (int k = 0; k < int'(n); k++) begin
            item             = random_item();
            item.first_entry = (k == 0);
            item.entry_magic = MagicEntry;
            if ($urandom_range(1))
               item.entry_type = TypeApp;
            align = (item.entry_type == TypeApp) ? AlignApp : AlignOther;
            case ($urandom_range(9))
               0: ;
               1: begin
                  item.flash_offset = $urandom_range(cursor);
                  item.flash_length = $urandom_range(1, 32'h40000);
               end
               default: begin
                  item.flash_offset = (cursor + align - 1) & ~(align - 1);
                  if ($urandom_range(11) == 0)
                     item.flash_offset |= $urandom_range(1, align - 1);
                  item.flash_length = ($urandom_range(15) == 0) ? '0 : $urandom_range(1, 64) << 12;
                  cursor = item.flash_offset + item.flash_length;
               end
            endcase
            push_item(item, 1'b0, '0);
         end
         item             = random_item();
         item.first_entry = 1'b0;
         case ($urandom_range(4))
            0, 1, 2: item.entry_magic = MagicEnd;
            3:       item.entry_magic = MagicMd5;
            default: ;
         endcase
         push_item(item, 1'b0, '0);
         n = $urandom_range(2);
         for (int k = 0; k < int'(n); k++) begin
            item             = random_item();
            item.first_entry = 1'b0;
            push_item(item, 1'b0, '0);
         end
      end
      tables_run++;
   endtask

   task automatic check_field(string field_name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, field_name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none actual status %0d", $time,
                     got.status);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("status", want.status, got.status);
            check_field("entry_index", want.entry_index, got.entry_index);
            check_field("is_empty", want.is_empty, got.is_empty);
            check_field("is_misaligned", want.is_misaligned, got.is_misaligned);
            check_field("does_overlap", want.does_overlap, got.does_overlap);
            check_field("is_encrypted", want.is_encrypted, got.is_encrypted);
            check_field("is_read_only", want.is_read_only, got.is_read_only);
            check_field("stored_total", want.stored_total, got.stored_total);
            status_tally[got.status]++;
            results_seen++;
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < StallLimit) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, StallLimit);
      $display("partition_table_entry_checker verification failed");
      $finish;
   end

   initial begin : stimulus
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;

      // rows marked 1 carry a hand-written result
      add_row(make_item(1'b1, MagicEntry, TypeApp, 8'h00, 32'h0, 32'h10000, 32'h0), 1'b1,
              make_want(ST_ACCEPTED, 7'd0, 5'b00000, 7'd1));
      add_row(make_item(1'b0, MagicEntry, 8'h01, 8'h02, 32'h10000, 32'h1000,
                        FlagEncrypted | FlagReadOnly), 1'b1,
              make_want(ST_ACCEPTED, 7'd1, 5'b00011, 7'd2));
      add_row(make_item(1'b0, MagicEntry, TypeApp, 8'h10, 32'h11000, 32'h1000, 32'h0), 1'b0, '0);
      add_row(make_item(1'b0, MagicEntry, 8'h01, 8'h01, 32'h8000, 32'h1000, 32'h0), 1'b0, '0);
      add_row(make_item(1'b0, MagicEntry, 8'h01, 8'h81, 32'h5000, 32'h0, 32'h0), 1'b0, '0);
      add_row(make_item(1'b0, MagicEntry, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff), 1'b0, '0);
      add_row(make_item(1'b0, MagicEntry, 8'h01, 8'h00, 32'hffff_f000, 32'h2000, 32'h0),
              1'b0, '0);
      add_row(make_item(1'b0, MagicEntry, TypeApp, 8'h20, 32'h20000, 32'h10000, FlagReadOnly),
              1'b0, '0);
      add_row(make_item(1'b0, MagicMd5, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
              make_want(ST_MD5, 7'd8, 5'b00000, 7'd8));
      add_row(make_item(1'b0, MagicEntry, 8'h00, 8'h00, 32'h0, 32'h1000, 32'h0), 1'b1,
              make_want(ST_IGNORED, 7'd8, 5'b00000, 7'd8));
      add_row(make_item(1'b1, MagicEnd, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
              make_want(ST_END, 7'd0, 5'b00000, 7'd0));
      add_row(make_item(1'b0, MagicEntry, 8'h00, 8'h00, 32'h0, 32'h1000, 32'h3), 1'b1,
              make_want(ST_IGNORED, 7'd0, 5'b00000, 7'd0));
      add_row(make_item(1'b1, 16'h0000, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
              make_want(ST_BAD_MAGIC, 7'd0, 5'b00000, 7'd0));
      add_row(make_item(1'b1, 16'h50ab, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
              make_want(ST_BAD_MAGIC, 7'd0, 5'b00000, 7'd0));
      add_row(make_item(1'b1, 16'haf55, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
              make_want(ST_BAD_MAGIC, 7'd0, 5'b00000, 7'd0));
      add_row(make_item(1'b1, MagicEntry, TypeApp, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
              make_want(ST_ACCEPTED, 7'd0, 5'b10000, 7'd1));
      add_row(make_item(1'b0, MagicEntry, TypeApp, 8'h00, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(make_item(1'b0, MagicEntry, 8'h02, 8'h00, 32'h0, 32'h1000, 32'h1), 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      while (useful_items < directed_rows.size() + RandomItems)
         run_random_table();
      req_ch.valid <= 1'b0;

      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (TableDepth + 8) @(posedge clock);

      $display("%0d items driven over %0d tables, %0d results checked", items_sent, tables_run,
               results_seen);
      $display("accepted %0d, end %0d, md5 %0d, bad magic %0d, full %0d, ignored %0d",
               status_tally[ST_ACCEPTED], status_tally[ST_END], status_tally[ST_MD5],
               status_tally[ST_BAD_MAGIC], status_tally[ST_FULL], status_tally[ST_IGNORED]);
      if (error_count == 0)
         $display("partition_table_entry_checker verification clean");
      else
         $display("partition_table_entry_checker verification failed");
      $finish;
   end
endmodule
